// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared constants, codes and types of the bitmask sprite collision block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int WORD_BITS = 16;
    localparam int MAX_ROWS  = 64;
    localparam int MAX_WORDS = 4;
    localparam int DEPTH     = MAX_ROWS * MAX_WORDS;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int WIDX_W    = $clog2(MAX_WORDS);
    localparam int ADDR_W    = ROW_W + WIDX_W;
    localparam int SH_W      = $clog2(WORD_BITS);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    localparam logic [2:0] CFG_A_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_A_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_A_WORDS  = 3'd2;
    localparam logic [2:0] CFG_B_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_B_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_B_WORDS  = 3'd5;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BOX   = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    typedef struct packed {
        logic                 en;
        logic                 sel_b;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } mem_rd_t;

endpackage

// ===== rtl/bsc_mask_store.sv =====
// ----------------------------------------------------------------------------
// bsc_mask_store
// The two sprite mask memories with one write port and registered reads.
// ----------------------------------------------------------------------------
module bsc_mask_store
    import bsc_pkg::*;
(
    input  logic                 clk,
    input  mem_wr_t              wr,
    input  mem_rd_t              rd,
    output logic [WORD_BITS-1:0] rd_a,
    output logic [WORD_BITS-1:0] rd_b
);

    logic [WORD_BITS-1:0] mem_a [0:DEPTH-1];
    logic [WORD_BITS-1:0] mem_b [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.sel_b)
        begin
            mem_a[wr.addr] <= wr.data;
        end
        if (wr.en && wr.sel_b)
        begin
            mem_b[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_a <= mem_a[rd.addr_a];
            rd_b <= mem_b[rd.addr_b];
        end
    end

endmodule

// ===== rtl/bitmask_sprite_collision.sv =====
// ----------------------------------------------------------------------------
// bitmask_sprite_collision
// Bounding box and pixel exact collision test of two bitmask sprites.
// ----------------------------------------------------------------------------
// The input stream carries two kinds of words, told apart by tuser bit 0.
// A load word writes one 16-bit mask word of sprite A or B and
// gives no result. A check word gives both sprite positions and returns one
// result word whose bit 0 is the hit flag.
// A check runs the box test in state BOX and then loads the result
// register in state DONE, where the result word is presented once it is
// loaded. A pixel test adds a SETUP state and then walks the overlapping
// rows, reading one word of each mask per cycle, and stops early on the
// first hit. The walk speed is set by the single read port of each mask
// memory. The block takes no new input word while a check runs.
// The result sits in an output register; the block goes back to idle as soon
// as it is there, so loads continue while the receiver stalls, and a second
// check waits only if the first result has not been taken yet.
// The configuration channel is always ready and must be written while idle;
// the block does not enforce it. Reset sets all sizes to one and clears
// the control state; mask memory content is undefined until written.
// ----------------------------------------------------------------------------
module bitmask_sprite_collision
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // row[5:0], word_index[7:6], mask_word[23:8], x_a[35:24], y_a[47:36],
    // x_b[59:48], y_b[71:60], pixel_check[72], zero fill
    input  logic [79:0] s_axis_tdata,
    // func[0], which_mask[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // hit[0], zero fill
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [2:0] state_reg, state_next;
    logic [6:0] a_width_reg, a_height_reg, b_width_reg, b_height_reg;
    logic [2:0] a_words_reg, b_words_reg;

    logic signed [11:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic               pc_reg;

    logic               xa_gt_reg, ya_gt_reg;
    logic [11:0]        dx_reg, dy_reg;

    logic [ROW_W-1:0]   ra_reg, rb_reg;
    logic [6:0]         rows_left_reg;
    logic [WIDX_W-1:0]  wa_reg, wb_reg;
    logic [2:0]         cnt_reg, j_reg;
    logic [SH_W-1:0]    sha_reg, shb_reg;
    logic [2:0]         na_reg, nb_reg;
    logic               issue_done_reg;

    logic               tag_valid_reg, tag_first_reg, tag_a_next_reg, tag_b_next_reg;
    logic [WORD_BITS-1:0] prev_a_reg, prev_b_reg;
    logic               hit_reg;
    logic               out_valid_reg, out_hit_reg;

    logic               in_acc, out_acc, cfg_acc;
    logic signed [13:0] xa_e, ya_e, xb_e, yb_e, dx_e, dy_e;
    logic               ovl, xa_gt, ya_gt;
    logic [6:0]         ha, hb;
    logic [2:0]         na, nb;
    logic [7:0]         woff;
    logic [7:0]         wa_full, wb_full;
    logic [11:0]        ra_full, rb_full;
    logic               rows_ok, words_ok;
    logic [11:0]        rows_a, rows_b;
    logic [7:0]         cnt_a, cnt_b;
    logic [6:0]         rows_cnt;
    logic [2:0]         cnt;
    logic               issuing;
    logic [3:0]         pos_a, pos_b;
    logic [WORD_BITS-1:0] rd_a, rd_b, al_a, al_b;
    logic               found;
    logic               done_load;
    mem_wr_t            wr;
    mem_rd_t            rd;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign cfg_acc = cfg_valid && cfg_ready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_hit_reg};

    assign wr.en    = in_acc && (s_axis_tuser[0] == FUNC_LOAD);
    assign wr.sel_b = s_axis_tuser[1];
    assign wr.addr  = {s_axis_tdata[5:0], s_axis_tdata[7:6]};
    assign wr.data  = s_axis_tdata[23:8];

    // Box test on the captured positions.
    assign xa_e  = {{2{xa_reg[11]}}, xa_reg};
    assign ya_e  = {{2{ya_reg[11]}}, ya_reg};
    assign xb_e  = {{2{xb_reg[11]}}, xb_reg};
    assign yb_e  = {{2{yb_reg[11]}}, yb_reg};
    assign ovl   = (xa_e + $signed({7'b0, a_width_reg}) > xb_e)
                && (xa_e < xb_e + $signed({7'b0, b_width_reg}))
                && (ya_e + $signed({7'b0, a_height_reg}) > yb_e)
                && (ya_e < yb_e + $signed({7'b0, b_height_reg}));
    assign xa_gt = xa_e > xb_e;
    assign ya_gt = ya_e > yb_e;
    assign dx_e  = xa_gt ? (xa_e - xb_e) : (xb_e - xa_e);
    assign dy_e  = ya_gt ? (ya_e - yb_e) : (yb_e - ya_e);

    // Alignment setup.
    assign ha      = (a_height_reg > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : a_height_reg;
    assign hb      = (b_height_reg > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : b_height_reg;
    assign na      = (a_words_reg > 3'(MAX_WORDS)) ? 3'(MAX_WORDS) : a_words_reg;
    assign nb      = (b_words_reg > 3'(MAX_WORDS)) ? 3'(MAX_WORDS) : b_words_reg;
    assign woff    = dx_reg[11:SH_W];
    assign wa_full = xa_gt_reg ? 8'd0 : woff;
    assign wb_full = xa_gt_reg ? woff : 8'd0;
    assign ra_full = ya_gt_reg ? 12'd0 : dy_reg;
    assign rb_full = ya_gt_reg ? dy_reg : 12'd0;
    assign rows_ok  = (ra_full < {5'b0, ha}) && (rb_full < {5'b0, hb});
    assign words_ok = (wa_full < {5'b0, na}) && (wb_full < {5'b0, nb});
    assign rows_a   = {5'b0, ha} - ra_full;
    assign rows_b   = {5'b0, hb} - rb_full;
    assign cnt_a    = {5'b0, na} - wa_full;
    assign cnt_b    = {5'b0, nb} - wb_full;
    assign rows_cnt = (rows_a < rows_b) ? rows_a[6:0] : rows_b[6:0];
    assign cnt      = (cnt_a < cnt_b) ? cnt_a[2:0] : cnt_b[2:0];

    // Walk: read one word of each mask per cycle, align with the previous one.
    assign issuing   = (state_reg == ST_WALK) && !issue_done_reg;
    assign pos_a     = {2'b0, wa_reg} + {1'b0, j_reg};
    assign pos_b     = {2'b0, wb_reg} + {1'b0, j_reg};
    assign rd.en     = issuing;
    assign rd.addr_a = {ra_reg, {WIDX_W{1'b0}}} + ADDR_W'(pos_a);
    assign rd.addr_b = {rb_reg, {WIDX_W{1'b0}}} + ADDR_W'(pos_b);

    assign al_a = (sha_reg == '0) ? prev_a_reg
                : ((prev_a_reg >> sha_reg)
                   | (tag_a_next_reg ? (rd_a << ((SH_W+1)'(WORD_BITS) - {1'b0, sha_reg}))
                                     : '0));
    assign al_b = (shb_reg == '0) ? prev_b_reg
                : ((prev_b_reg >> shb_reg)
                   | (tag_b_next_reg ? (rd_b << ((SH_W+1)'(WORD_BITS) - {1'b0, shb_reg}))
                                     : '0));
    assign found = (state_reg == ST_WALK) && tag_valid_reg && !tag_first_reg
                && ((al_a & al_b) != '0);

    assign done_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    bsc_mask_store u_store
    (
        .clk  (clk),
        .wr   (wr),
        .rd   (rd),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (s_axis_tuser[0] == FUNC_CHECK))
                begin
                    state_next = ST_BOX;
                end
            end
            ST_BOX:
            begin
                state_next = (ovl && pc_reg) ? ST_SETUP : ST_DONE;
            end
            ST_SETUP:
            begin
                state_next = (rows_ok && words_ok) ? ST_WALK : ST_DONE;
            end
            ST_WALK:
            begin
                if (found || (issue_done_reg && !tag_valid_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            a_width_reg    <= 7'd1;
            a_height_reg   <= 7'd1;
            a_words_reg    <= 3'd1;
            b_width_reg    <= 7'd1;
            b_height_reg   <= 7'd1;
            b_words_reg    <= 3'd1;
            out_valid_reg  <= 1'b0;
            tag_valid_reg  <= 1'b0;
            issue_done_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tag_valid_reg <= issuing && !found;
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    CFG_A_WIDTH:  a_width_reg  <= cfg_data;
                    CFG_A_HEIGHT: a_height_reg <= cfg_data;
                    CFG_A_WORDS:  a_words_reg  <= cfg_data[2:0];
                    CFG_B_WIDTH:  b_width_reg  <= cfg_data;
                    CFG_B_HEIGHT: b_height_reg <= cfg_data;
                    CFG_B_WORDS:  b_words_reg  <= cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end
            if (done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_SETUP)
            begin
                issue_done_reg <= 1'b0;
            end
            else if (issuing && (j_reg == cnt_reg) && (rows_left_reg == 7'd1))
            begin
                issue_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            xa_reg <= s_axis_tdata[35:24];
            ya_reg <= s_axis_tdata[47:36];
            xb_reg <= s_axis_tdata[59:48];
            yb_reg <= s_axis_tdata[71:60];
            pc_reg <= s_axis_tdata[72];
        end
        if (state_reg == ST_BOX)
        begin
            hit_reg   <= ovl && !pc_reg;
            xa_gt_reg <= xa_gt;
            ya_gt_reg <= ya_gt;
            dx_reg    <= dx_e[11:0];
            dy_reg    <= dy_e[11:0];
        end
        if (state_reg == ST_SETUP)
        begin
            hit_reg       <= 1'b0;
            ra_reg        <= ra_full[ROW_W-1:0];
            rb_reg        <= rb_full[ROW_W-1:0];
            rows_left_reg <= rows_cnt;
            wa_reg        <= wa_full[WIDX_W-1:0];
            wb_reg        <= wb_full[WIDX_W-1:0];
            cnt_reg       <= cnt;
            j_reg         <= 3'd0;
            sha_reg       <= xa_gt_reg ? '0 : dx_reg[SH_W-1:0];
            shb_reg       <= xa_gt_reg ? dx_reg[SH_W-1:0] : '0;
            na_reg        <= na;
            nb_reg        <= nb;
        end
        if (issuing)
        begin
            tag_first_reg  <= (j_reg == 3'd0);
            tag_a_next_reg <= (pos_a < {1'b0, na_reg});
            tag_b_next_reg <= (pos_b < {1'b0, nb_reg});
            if (j_reg == cnt_reg)
            begin
                j_reg         <= 3'd0;
                ra_reg        <= ra_reg + 1'b1;
                rb_reg        <= rb_reg + 1'b1;
                rows_left_reg <= rows_left_reg - 7'd1;
            end
            else
            begin
                j_reg <= j_reg + 3'd1;
            end
        end
        if (tag_valid_reg)
        begin
            prev_a_reg <= rd_a;
            prev_b_reg <= rd_b;
        end
        if (found)
        begin
            hit_reg <= 1'b1;
        end
        if (done_load)
        begin
            out_hit_reg <= hit_reg;
        end
    end

endmodule
